// ----- hdl/gre_pkg.sv -----
// shared types and constants of the gaussian row eliminator
`default_nettype none

package gre_pkg;

  localparam int DataW   = 32;
  localparam int FracW   = 16;
  localparam int ColW    = 8;
  localparam int RowLenW = 9;
  localparam int NumW    = DataW + FracW;
  localparam int ProdW   = 2 * DataW;

  localparam logic [RowLenW-1:0] RowLenReset = RowLenW'(256);

  // register selects on paddr[2]
  localparam logic RegPivotCol = 1'b0;
  localparam logic RegRowLen   = 1'b1;

  // request codes
  localparam logic ReqPivotLoad = 1'b0;
  localparam logic ReqRowElem   = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [ColW-1:0]         col_index;
    logic signed [DataW-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic [ColW-1:0]         result_col;
    logic                    last_in_row;
    logic                    pivot_zero;
    logic                    saturated;
  } out_word_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [DataW-1:0] quot;
  } div_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } core_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_e;

endpackage

`default_nettype wire

// ----- hdl/gre_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module gre_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/gre_divider.sv -----
// radix-2 restoring divider for the row factor, one quotient bit per cycle
`default_nettype none

module gre_divider (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [gre_pkg::NumW-1:0]     dividend_i,
  input  wire logic signed [gre_pkg::DataW-1:0]    divisor_i,
  output gre_pkg::div_result_t                     res_o
);

  localparam int NumW  = gre_pkg::NumW;
  localparam int DataW = gre_pkg::DataW;
  localparam int CntW  = $clog2(NumW);
  localparam logic [NumW-1:0] MinMag = NumW'(1) << (DataW - 1);

  gre_pkg::div_state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [DataW:0]   rem_q, rem_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;

  logic [DataW:0]   shifted;
  logic             fits;
  logic             big;
  logic             sat;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gre_pkg::DIV_IDLE: begin
        if (start_i) state_d = gre_pkg::DIV_RUN;
      end
      gre_pkg::DIV_RUN: begin
        if (cnt_q == CntW'(NumW - 1)) state_d = gre_pkg::DIV_FIX;
      end
      gre_pkg::DIV_FIX: begin
        state_d = gre_pkg::DIV_IDLE;
      end
      default: state_d = gre_pkg::DIV_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    shifted = {rem_q[DataW-1:0], quo_q[NumW-1]};
    fits    = shifted >= {1'b0, dvs_q};
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    case (state_q)
      gre_pkg::DIV_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          quo_d = dividend_i[NumW-1] ? NumW'(-dividend_i) : NumW'(dividend_i);
          rem_d = '0;
          dvs_d = divisor_i[DataW-1] ? DataW'(-divisor_i) : DataW'(divisor_i);
          neg_d = dividend_i[NumW-1] ^ divisor_i[DataW-1];
        end
      end
      gre_pkg::DIV_RUN: begin
        cnt_d = cnt_q + CntW'(1);
        rem_d = fits ? (shifted - {1'b0, dvs_q}) : shifted;
        quo_d = {quo_q[NumW-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  // outputs: sign and clip of the magnitude quotient
  always_comb begin
    big  = |quo_q[NumW-1:DataW-1];
    sat  = big && !(neg_q && (quo_q == MinMag));
    res_o.done = (state_q == gre_pkg::DIV_FIX);
    res_o.sat  = sat;
    if (sat) begin
      res_o.quot = neg_q ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      res_o.quot = neg_q ? DataW'(-quo_q[DataW-1:0]) : quo_q[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gre_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

endmodule

`default_nettype wire

// ----- hdl/gaussian_row_eliminator_core.sv -----
// top level of the gaussian elimination row-update engine
// usage:
//   in channel: in_valid_i / in_stall_o with an in_word_t word. a word is taken at a rising
//   edge with valid high and stall low. pivot-load words write one pivot-row element into
//   the pivot store; row words carry one element of the row being reduced, ascending column
//   order, and every pivot entry they touch must have been loaded first.
//   out channel: out_valid_o / out_stall_i with an out_word_t word, one per row word.
//   config: apb write/read of pivot_col (addr 0) and row_len (addr 4), only while idle.
// flow:
//   a pivot load leaves the block idle, and the next word can follow right away.
//   a row element below the pivot column passes through the pivot and out states into the
//   output register, any other element through the pivot, multiply and out states (pivot
//   read, 32x32 multiply, subtract and clip). a pivot column element with a nonzero pivot also
//   runs the restoring divider, one quotient bit a cycle over 48 bits plus a sign/clip step.
//   in_stall_o is high while a row word is in flight, so no new word is taken until that
//   row word has been loaded into the output register.
// reset: state, factor and flags clear, pivot_col goes to 0 and row_len to 256; the pivot
//   store holds garbage until loaded.
// stall: the output register holds a finished word; a new word can be taken meanwhile,
//   and it waits in its final step until the output register frees up.
`default_nettype none

module gaussian_row_eliminator_core #(
  parameter int MAX_COLS = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire gre_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output gre_pkg::out_word_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DataW   = gre_pkg::DataW;
  localparam int FracW   = gre_pkg::FracW;
  localparam int ColW    = gre_pkg::ColW;
  localparam int RowLenW = gre_pkg::RowLenW;
  localparam int ProdW   = gre_pkg::ProdW;
  localparam int AddrW   = $clog2(MAX_COLS);

  // config registers
  logic [ColW-1:0]    pivot_col_q;
  logic [RowLenW-1:0] row_len_q;
  logic               cfg_we;

  gre_pkg::core_state_e state_q, state_d;

  // item under work
  logic [ColW-1:0]         col_q;
  logic signed [DataW-1:0] elem_q;
  logic                    pass_q;
  logic                    at_piv_q;
  logic                    inrange_q;
  logic signed [DataW-1:0] p_q;

  // row state
  logic signed [DataW-1:0] factor_q;
  logic                    fpz_q;
  logic                    fsat_q;

  logic signed [ProdW-1:0] prod_q;

  gre_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // handshake and control
  logic in_acc;
  logic row_acc;
  logic piv_acc;
  logic in_range;
  logic div_start;
  logic out_load;
  logic out_blocked;

  logic [AddrW+ColW-1:0] col_ext;
  logic [AddrW-1:0]      ram_addr;
  logic [DataW-1:0]      ram_rdata;
  logic signed [DataW-1:0] piv_val;
  logic                  piv_nz;

  gre_pkg::div_result_t div_res;

  // subtract and clip
  logic signed [ProdW-1:0] q_shift;
  logic signed [ProdW:0]   diff;
  logic                    clip;
  logic signed [DataW-1:0] clipped;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_col_q <= '0;
      row_len_q   <= gre_pkg::RowLenReset;
    end else if (cfg_we) begin
      case (paddr[2])
        gre_pkg::RegPivotCol: pivot_col_q <= pwdata[ColW-1:0];
        gre_pkg::RegRowLen:   row_len_q   <= pwdata[RowLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gre_pkg::RegPivotCol: prdata = 32'(pivot_col_q);
      gre_pkg::RegRowLen:   prdata = 32'(row_len_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pivot store
  assign in_acc   = in_valid_i && !in_stall_o;
  assign row_acc  = in_acc && (in_data_i.req_type == gre_pkg::ReqRowElem);
  assign piv_acc  = in_acc && (in_data_i.req_type == gre_pkg::ReqPivotLoad);
  assign in_range = 32'(in_data_i.col_index) < MAX_COLS;
  assign col_ext  = (AddrW + ColW)'(in_data_i.col_index);
  assign ram_addr = col_ext[AddrW-1:0];

  gre_ram #(
    .Width (DataW),
    .Depth (MAX_COLS)
  ) u_pivot_store (
    .clk_i   (clk_i),
    .we_i    (piv_acc && in_range),
    .waddr_i (ram_addr),
    .wdata_i (in_data_i.element_value),
    .re_i    (row_acc),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // columns past the store read as zero
  assign piv_val = inrange_q ? $signed(ram_rdata) : '0;
  assign piv_nz  = (piv_val != '0);

  // ---------------------------------------------------------------- divider
  gre_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({elem_q, {FracW{1'b0}}}),
    .divisor_i  (piv_val),
    .res_o      (div_res)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_blocked = out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gre_pkg::ST_IDLE: begin
        if (row_acc) state_d = gre_pkg::ST_PIVOT;
      end
      gre_pkg::ST_PIVOT: begin
        if (pass_q) begin
          state_d = gre_pkg::ST_OUT;
        end else if (at_piv_q && piv_nz) begin
          state_d = gre_pkg::ST_DIV;
        end else begin
          state_d = gre_pkg::ST_MUL;
        end
      end
      gre_pkg::ST_DIV: begin
        if (div_res.done) state_d = gre_pkg::ST_MUL;
      end
      gre_pkg::ST_MUL: begin
        state_d = gre_pkg::ST_OUT;
      end
      gre_pkg::ST_OUT: begin
        if (!out_blocked) state_d = gre_pkg::ST_IDLE;
      end
      default: state_d = gre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != gre_pkg::ST_IDLE);
    div_start  = (state_q == gre_pkg::ST_PIVOT) && !pass_q && at_piv_q && piv_nz;
    out_load   = (state_q == gre_pkg::ST_OUT) && !out_blocked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture of the element and its pivot
  always_ff @(posedge clk_i) begin
    if (row_acc) begin
      col_q     <= in_data_i.col_index;
      elem_q    <= in_data_i.element_value;
      pass_q    <= in_data_i.col_index < pivot_col_q;
      at_piv_q  <= in_data_i.col_index == pivot_col_q;
      inrange_q <= in_range;
    end
    if (state_q == gre_pkg::ST_PIVOT) begin
      p_q <= piv_val;
    end
    if (state_q == gre_pkg::ST_MUL) begin
      prod_q <= factor_q * p_q;
    end
  end

  // row factor and its flags, latched at the pivot column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= '0;
      fpz_q    <= 1'b0;
      fsat_q   <= 1'b0;
    end else if ((state_q == gre_pkg::ST_PIVOT) && at_piv_q && !piv_nz) begin
      factor_q <= '0;
      fpz_q    <= 1'b1;
      fsat_q   <= 1'b0;
    end else if ((state_q == gre_pkg::ST_DIV) && div_res.done) begin
      factor_q <= div_res.quot;
      fpz_q    <= 1'b0;
      fsat_q   <= div_res.sat;
    end
  end

  // element minus floor(factor * pivot / 2^16), clipped
  always_comb begin
    q_shift = prod_q >>> FracW;
    diff    = (ProdW + 1)'(elem_q) - (ProdW + 1)'(q_shift);
    clip    = !((&diff[ProdW:DataW-1]) || !(|diff[ProdW:DataW-1]));
    if (clip) begin
      clipped = diff[ProdW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      clipped = diff[DataW-1:0];
    end
  end

  always_comb begin
    out_d.result_col  = col_q;
    out_d.last_in_row = RowLenW'(col_q) == RowLenW'(row_len_q - RowLenW'(1));
    if (pass_q) begin
      out_d.result_value = elem_q;
      out_d.pivot_zero   = 1'b0;
      out_d.saturated    = 1'b0;
    end else begin
      out_d.result_value = clipped;
      out_d.pivot_zero   = fpz_q;
      out_d.saturated    = fsat_q || clip;
    end
  end

  // ---------------------------------------------------------------- output register
  assign out_valid_d = out_load || out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/gre_checker.sv -----
// port-level checks of the row eliminator, bound to the top level
`default_nettype none

module gre_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire gre_pkg::in_word_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire gre_pkg::out_word_t out_data_o
);

  // a stalled output word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // a row word keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.req_type == gre_pkg::ReqRowElem)
    |=> in_stall_o)
    else $error("row word taken but block not busy");

  // a pivot load never makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.req_type == gre_pkg::ReqPivotLoad)
    |=> !in_stall_o)
    else $error("pivot load made block busy");

  // a new output word only comes from a row word in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a row word in flight");

endmodule

bind gaussian_row_eliminator_core gre_checker u_gre_checker (.*);

`default_nettype wire

// ----- bench/gaussian_row_eliminator_core_tb.sv -----
// self-checking testbench of the gaussian row eliminator core
`timescale 1ns / 1ps

module gaussian_row_eliminator_core_tb;

  // q16.16 clip bounds in 64-bit arithmetic
  localparam longint QMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint QMin = -64'sh0000_0000_8000_0000;
  // quiet cycles after the last result, covers a divide still in flight
  localparam int SettleCycles = 80;
  // long receiver hold-off so the core backs up into its input
  localparam int HoldCycles = 400;
  localparam int TargetWords = 750;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // in channel
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  gre_pkg::in_word_t  in_data_i = '0;
  // out channel
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  gre_pkg::out_word_t out_data_o;
  // apb
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gaussian_row_eliminator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // words waiting to be offered, and updated elements waiting to come out
  gre_pkg::in_word_t  stim_words_q[$];
  gre_pkg::out_word_t updated_elems_q[$];

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // receiver hold-off
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int err_cnt      = 0;
  int words_queued = 0;

  // which pivot entries the stimulus has loaded so far, keeps row words off unwritten entries
  bit pivot_written [256];

  // ---------------------------------------------------------------------------
  // row-update predictor: own copy of the registers, pivot row and row factor
  // ---------------------------------------------------------------------------
  logic [gre_pkg::ColW-1:0]         cfg_pivot_col = '0;
  logic [gre_pkg::RowLenW-1:0]      cfg_row_len   = gre_pkg::RowLenReset;
  logic signed [gre_pkg::DataW-1:0] pivot_row [256];
  longint                           row_factor_q  = 0;
  bit                               row_pz_q      = 1'b0;
  bit                               row_fsat_q    = 1'b0;

  initial begin
    foreach (pivot_row[i]) pivot_row[i] = '0;
  end

  function automatic void row_update_predict(input gre_pkg::in_word_t w, output bit has_res,
                                             output gre_pkg::out_word_t r);
    longint elem, piv, prod, quo, upd;
    bit     sat;
    r       = '0;
    has_res = 1'b0;
    elem    = longint'($signed(w.element_value));
    // pivot loads only fill the pivot row
    if (w.req_type == gre_pkg::ReqPivotLoad) begin
      pivot_row[w.col_index] = w.element_value;
      return;
    end
    has_res = 1'b1;
    upd     = elem;
    sat     = 1'b0;
    if (w.col_index >= cfg_pivot_col) begin
      // the pivot column latches the row factor, zero pivot forces it to zero
      if (w.col_index == cfg_pivot_col) begin
        piv        = longint'(pivot_row[w.col_index]);
        row_fsat_q = 1'b0;
        if (piv == 0) begin
          row_factor_q = 0;
          row_pz_q     = 1'b1;
        end else begin
          row_pz_q = 1'b0;
          quo      = (elem * 65536) / piv;
          if (quo > QMax) begin
            quo        = QMax;
            row_fsat_q = 1'b1;
          end else if (quo < QMin) begin
            quo        = QMin;
            row_fsat_q = 1'b1;
          end
          row_factor_q = quo;
        end
      end
      // q32.32 product back to q16.16, floor
      piv  = longint'(pivot_row[w.col_index]);
      prod = row_factor_q * piv;
      quo  = prod >>> gre_pkg::FracW;
      upd  = elem - quo;
      sat  = row_fsat_q;
      if (upd > QMax) begin
        upd = QMax;
        sat = 1'b1;
      end else if (upd < QMin) begin
        upd = QMin;
        sat = 1'b1;
      end
      r.pivot_zero = row_pz_q;
    end
    r.result_value = upd[gre_pkg::DataW-1:0];
    r.result_col   = w.col_index;
    r.last_in_row  = ({1'b0, w.col_index} == gre_pkg::RowLenW'(cfg_row_len - 1));
    r.saturated    = sat;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: holds a stalled word, otherwise offers the next one unless idling
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit                 has_res;
    gre_pkg::out_word_t res_w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        row_update_predict(in_data_i, has_res, res_w);
        if (has_res) updated_elems_q.push_back(res_w);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (stim_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= stim_words_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // hold-off counter, armed once from the stimulus
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each taken word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gre_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (updated_elems_q.size() == 0) begin
          $error("unexpected result word, col %0d", out_data_o.result_col);
          err_cnt++;
        end else begin
          exp_w = updated_elems_q.pop_front();
          if (out_data_o.result_value !== exp_w.result_value) begin
            $error("result_value: expected %h, got %h", exp_w.result_value,
                   out_data_o.result_value);
            err_cnt++;
          end
          if (out_data_o.result_col !== exp_w.result_col) begin
            $error("result_col: expected %0d, got %0d", exp_w.result_col,
                   out_data_o.result_col);
            err_cnt++;
          end
          if (out_data_o.last_in_row !== exp_w.last_in_row) begin
            $error("last_in_row: expected %b, got %b", exp_w.last_in_row,
                   out_data_o.last_in_row);
            err_cnt++;
          end
          if (out_data_o.pivot_zero !== exp_w.pivot_zero) begin
            $error("pivot_zero: expected %b, got %b", exp_w.pivot_zero,
                   out_data_o.pivot_zero);
            err_cnt++;
          end
          if (out_data_o.saturated !== exp_w.saturated) begin
            $error("saturated: expected %b, got %b", exp_w.saturated,
                   out_data_o.saturated);
            err_cnt++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_word(input logic rt, input int col, input logic [31:0] val);
    gre_pkg::in_word_t w;
    w.req_type      = rt;
    w.col_index     = col[gre_pkg::ColW-1:0];
    w.element_value = val;
    stim_words_q.push_back(w);
    words_queued++;
    if (rt == gre_pkg::ReqPivotLoad) pivot_written[col] = 1'b1;
  endfunction

  // mostly moderate values around +-16.0, some full-range and corner values
  function automatic logic [31:0] rand_elem();
    int moderate;
    moderate = int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return moderate;
    endcase
  endfunction

  // one row in ascending column order, dense for short rows, sparse for long ones;
  // sprinkled with stray pivot loads, stray row words, and sometimes a dropped pivot element
  function automatic void push_row(input int pc, input int rl);
    int last_col;
    int stray;
    last_col = (rl > 256) ? 255 : rl - 1;
    for (int c = 0; c <= last_col; c++) begin
      if ($urandom_range(15) == 0) begin
        stray = $urandom_range(255);
        if ($urandom_range(1) == 0)
          push_word(gre_pkg::ReqPivotLoad, stray, rand_elem());
        else if (stray < pc || pivot_written[stray])
          push_word(gre_pkg::ReqRowElem, stray, rand_elem());
      end
      if (c == pc && $urandom_range(19) == 0) continue;
      if (rl <= 32 || c == pc || c == last_col || $urandom_range(15) == 0)
        push_word(gre_pkg::ReqRowElem, c, rand_elem());
    end
  endfunction

  // apb write, setup then access; mirror updated once the access edge has passed
  task automatic write_reg(input logic regsel, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (regsel == gre_pkg::RegPivotCol) cfg_pivot_col = val[gre_pkg::ColW-1:0];
    else cfg_row_len = val[gre_pkg::RowLenW-1:0];
  endtask

  // everything sent and answered, then a quiet stretch for a trailing pivot load or divide
  task automatic wait_drained();
    do @(negedge clk_i);
    while (stim_words_q.size() != 0 || in_valid_i || updated_elems_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int pc, rl, phase_start, last_load;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset registers: pivot column 0, rows of 256
    push_word(gre_pkg::ReqPivotLoad, 0,   32'h0001_0000);
    push_word(gre_pkg::ReqPivotLoad, 1,   32'h7FFF_FFFF);
    push_word(gre_pkg::ReqPivotLoad, 255, 32'h8000_0000);
    push_word(gre_pkg::ReqRowElem,   0,   32'h7FFF_FFFF);  // factor at the top of the range
    push_word(gre_pkg::ReqRowElem,   1,   32'h8000_0000);  // result clips low
    push_word(gre_pkg::ReqRowElem,   255, 32'h0000_0000);  // last column, result clips high
    push_word(gre_pkg::ReqPivotLoad, 0,   32'h0000_0001);  // tiny pivot
    push_word(gre_pkg::ReqRowElem,   0,   32'h4000_0000);  // factor clips
    push_word(gre_pkg::ReqRowElem,   1,   32'hFFFF_FFFF);
    push_word(gre_pkg::ReqPivotLoad, 0,   32'h0000_0000);  // zero pivot
    push_word(gre_pkg::ReqRowElem,   0,   32'h0000_3039);
    push_word(gre_pkg::ReqRowElem,   1,   32'h8000_0000);
    push_word(gre_pkg::ReqRowElem,   255, 32'h7FFF_FFFF);
    push_word(gre_pkg::ReqRowElem,   1,   32'h0002_0000);  // ahead of its pivot column
    push_word(gre_pkg::ReqPivotLoad, 0,   32'hFFFE_0000);
    push_word(gre_pkg::ReqRowElem,   0,   32'h0001_0000);  // negative factor
    push_word(gre_pkg::ReqRowElem,   1,   32'h0003_8000);

    // directed, pivot column at its top and one-element rows
    wait_drained();
    write_reg(gre_pkg::RegPivotCol, 32'd255);
    write_reg(gre_pkg::RegRowLen, 32'd1);
    @(negedge clk_i);
    push_word(gre_pkg::ReqRowElem, 0,   32'h1234_5678);    // below the pivot, marked last
    push_word(gre_pkg::ReqRowElem, 128, 32'h8000_0000);    // past the row length
    push_word(gre_pkg::ReqRowElem, 255, 32'h7FFF_FFFF);

    // random elimination rounds, each with its own registers and idling
    for (int k = 0; words_queued < TargetWords; k++) begin
      case (k % 6)
        0: begin
          pc = 0;
          rl = $urandom_range(2, 16);
        end
        1: begin
          pc = 255;
          rl = 256;
        end
        2: begin
          pc = $urandom_range(192, 255);
          rl = 256;
        end
        3: begin
          pc = $urandom_range(3);
          rl = 1;
        end
        4: begin
          rl = $urandom_range(2, 24);
          pc = $urandom_range(rl - 1);
        end
        default: begin
          // pivot past the row, the row's own elements pass through
          rl = $urandom_range(2, 24);
          pc = $urandom_range(rl, 255);
        end
      endcase

      wait_drained();
      write_reg(gre_pkg::RegPivotCol, pc);
      write_reg(gre_pkg::RegRowLen, rl);
      @(negedge clk_i);

      case (k % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase

      // fresh pivot row from the pivot column to the end of the row
      last_load = (rl > 256) ? 255 : rl - 1;
      for (int c = pc; c <= last_load; c++)
        push_word(gre_pkg::ReqPivotLoad, c,
                  (c == pc && $urandom_range(7) == 0) ? 32'h0 : rand_elem());

      phase_start = words_queued;
      while (words_queued - phase_start < 45) push_row(pc, rl);

      // receiver freezes while the sender keeps offering
      if (k == 4) hold_go <= 1'b1;
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- gaussian_row_eliminator_core.f -----
hdl/gre_pkg.sv
hdl/gre_ram.sv
hdl/gre_divider.sv
hdl/gaussian_row_eliminator_core.sv
hdl/gre_checker.sv
bench/gaussian_row_eliminator_core_tb.sv
